// ----- rtl/core/dtl_pkg.sv -----
// Package for the delay line and one-pole low-pass: sizes, register codes, stage types.
package dtl_pkg;

    localparam int DELAY_DEPTH = 65536;
    localparam int SAMPLE_BITS = 16;
    localparam int ADDR_W      = $clog2(DELAY_DEPTH);
    localparam int FILL_W      = $clog2(DELAY_DEPTH + 1);
    localparam int LEVEL_W     = 32;
    localparam int COEF_W      = 16;
    localparam int LEN_W       = 16;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [LEN_W-1:0]  DELAY_LENGTH_RESET = LEN_W'(55125);
    localparam logic [COEF_W-1:0] FILTER_COEF_RESET  = COEF_W'(2686);

    // register index, taken from paddr[2]
    typedef enum logic [0:0] {
        REG_DELAY_LENGTH = 1'b0,
        REG_FILTER_COEF  = 1'b1
    } dtl_reg_t;

    // delayed sample handed from the delay stage to the filter
    typedef struct packed {
        logic                          valid;
        logic signed [SAMPLE_BITS-1:0] sample;
    } dtl_tap_t;

endpackage

// ----- rtl/core/dtl_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module dtl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/core/dtl_delay.sv -----
// Delay stage: circular sample store, write pointer, fill counter and tap read.
module dtl_delay
    import dtl_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          advance,
    input  logic                          s_valid,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic [LEN_W-1:0]              delay_length,
    output dtl_tap_t                      tap
);

    logic [ADDR_W-1:0]            wp_reg, wp_next;
    logic [FILL_W-1:0]            fill_reg, fill_next;
    logic [ADDR_W-1:0]            len_sat;
    logic [ADDR_W-1:0]            rd_addr;
    logic [ADDR_W:0]              rd_wide;
    logic                         acc;
    logic                         use_tap;
    logic                         bypass;
    logic                         valid_reg;
    logic                         use_reg;
    logic                         bypass_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic [SAMPLE_BITS-1:0]       rdata;

    assign acc = advance && s_valid;

    // lengths beyond the store saturate at depth-1
    always_comb begin
        if (32'(delay_length) > 32'(DELAY_DEPTH - 1)) begin
            len_sat = ADDR_W'(DELAY_DEPTH - 1);
        end else begin
            len_sat = ADDR_W'(delay_length);
        end
    end

    always_comb begin
        if (32'(wp_reg) == 32'(DELAY_DEPTH - 1)) begin
            wp_next = '0;
        end else begin
            wp_next = wp_reg + 1'b1;
        end
        if (32'(fill_reg) == 32'(DELAY_DEPTH)) begin
            fill_next = fill_reg;
        end else begin
            fill_next = fill_reg + 1'b1;
        end
        if (wp_reg >= len_sat) begin
            rd_wide = {1'b0, wp_reg} - {1'b0, len_sat};
        end else begin
            rd_wide = {1'b0, wp_reg} + (ADDR_W+1)'(DELAY_DEPTH) - {1'b0, len_sat};
        end
        rd_addr = rd_wide[ADDR_W-1:0];
    end

    // tap only once the entry has been written; zero length reads this very sample
    assign use_tap = fill_next > FILL_W'(len_sat);
    assign bypass  = (len_sat == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg    <= '0;
            fill_reg  <= '0;
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= s_valid;
            if (s_valid) begin
                wp_reg   <= wp_next;
                fill_reg <= fill_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            use_reg    <= use_tap;
            bypass_reg <= bypass;
            sample_reg <= sample;
        end
    end

    dtl_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DELAY_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (acc),
        .waddr (wp_reg),
        .wdata (sample),
        .re    (advance),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    always_comb begin
        tap.valid = valid_reg;
        if (bypass_reg) begin
            tap.sample = sample_reg;
        end else if (use_reg) begin
            tap.sample = $signed(rdata);
        end else begin
            tap.sample = '0;
        end
    end

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(fill_reg) <= 32'(DELAY_DEPTH))
        else $error("fill count beyond store depth");

    a_no_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        acc && !bypass |-> rd_addr != wp_reg)
        else $error("tap read collides with write outside pass-through");

    a_tap_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        acc |=> valid_reg)
        else $error("accepted sample did not reach tap stage");

endmodule

// ----- rtl/core/dtl_filter.sv -----
// One-pole low-pass: Q1.31 level update and rescale to a signed sample.
module dtl_filter
    import dtl_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          advance,
    input  dtl_tap_t                      tap,
    input  logic [COEF_W-1:0]             alpha,
    output logic                          m_valid,
    output logic signed [SAMPLE_BITS-1:0] m_data
);

    localparam int PROD_W  = COEF_W + 1 + LEVEL_W + 1;
    localparam int STEP_W  = PROD_W - COEF_W;
    localparam int SCALE_W = LEVEL_W + SAMPLE_BITS - 1;

    logic signed [LEVEL_W-1:0]     y_reg, y_next;
    logic signed [LEVEL_W-1:0]     x;
    logic signed [LEVEL_W:0]       diff;
    logic signed [PROD_W-1:0]      prod;
    logic signed [STEP_W-1:0]      step;
    logic signed [STEP_W-1:0]      y_sum;
    logic                          v2_reg;
    logic                          m_valid_reg;
    logic signed [SAMPLE_BITS-1:0] m_data_reg;
    logic [LEVEL_W-1:0]            mag;
    logic [SCALE_W-1:0]            scaled;
    logic [SAMPLE_BITS-1:0]        res;
    logic signed [SAMPLE_BITS-1:0] out_val;

    // y += floor(alpha*(x-y)/2^16); stays between y and x so no wrap
    always_comb begin
        x      = {tap.sample, {(LEVEL_W - SAMPLE_BITS){1'b0}}};
        diff   = (LEVEL_W+1)'(x) - (LEVEL_W+1)'(y_reg);
        prod   = $signed({1'b0, alpha}) * diff;
        step   = prod[PROD_W-1:COEF_W];
        y_sum  = STEP_W'(y_reg) + step;
        y_next = y_sum[LEVEL_W-1:0];
    end

    // |y| * (2^(N-1)-1) >> 31, by shift and subtract, sign restored after
    always_comb begin
        mag     = y_reg[LEVEL_W-1] ? (~y_reg + 1'b1) : y_reg;
        scaled  = {mag, {(SAMPLE_BITS - 1){1'b0}}} - SCALE_W'(mag);
        res     = scaled[SCALE_W-1:LEVEL_W-1];
        out_val = y_reg[LEVEL_W-1] ? $signed(~res + 1'b1) : $signed(res);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            y_reg       <= '0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            v2_reg      <= tap.valid;
            m_valid_reg <= v2_reg;
            if (tap.valid) begin
                y_reg <= y_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && v2_reg) begin
            m_data_reg <= out_val;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- rtl/core/delay_then_one_pole_lowpass.sv -----
// Top level of the delay line followed by a one-pole low-pass filter.
//
// Usage:
//   Input stream s_*: one signed PCM sample per transaction in s_tdata.
//   Output stream m_*: one delayed, low-pass filtered sample per input.
//   APB port: register 0 (byte 0x0) delay_length, register 1 (byte 0x4)
//   filter_coefficient (alpha, Q0.16). Write only while the stream is idle.
//   Samples leave the delay line as zero until delay_length+1 have arrived;
//   a delay_length of zero passes the current sample straight to the filter.
// Throughput: one transaction per cycle while the output is not stalled,
//   bounded by the single write and single read port of the delay store.
// Pipeline: from input acceptance to m_tvalid a sample passes the store read,
//   filter update and output rescale register.
// Stall: all stages move together; while m_tvalid is high and m_tready low
//   nothing advances and s_tready is low. s_tready stays high whenever the
//   output register is empty or being taken.
// Reset (aresetn low, synchronous): pointer, fill count and filter level
//   clear, registers return to 55125 and 2686. The store itself is not
//   cleared: the fill count keeps unwritten entries from being used.
module delay_then_one_pole_lowpass
    import dtl_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [SAMPLE_BITS-1:0] s_tdata,   // [15:0] sample_in
    // output stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [SAMPLE_BITS-1:0] m_tdata,   // [15:0] sample_out
    // configuration
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    logic [LEN_W-1:0]              delay_length_reg;
    logic [COEF_W-1:0]             filter_coefficient_reg;
    logic                          cfg_write;
    dtl_reg_t                      reg_sel;
    logic                          advance;
    dtl_tap_t                      tap;
    logic signed [SAMPLE_BITS-1:0] filt_data;

    // ---- configuration registers ----
    assign pready    = 1'b1;
    assign reg_sel   = dtl_reg_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_length_reg       <= DELAY_LENGTH_RESET;
            filter_coefficient_reg <= FILTER_COEF_RESET;
        end else if (cfg_write) begin
            case (reg_sel)
                REG_DELAY_LENGTH: delay_length_reg       <= pwdata[LEN_W-1:0];
                REG_FILTER_COEF:  filter_coefficient_reg <= pwdata[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_DELAY_LENGTH: prdata = APB_DATA_W'(delay_length_reg);
            REG_FILTER_COEF:  prdata = APB_DATA_W'(filter_coefficient_reg);
            default:          prdata = '0;
        endcase
    end

    // ---- pipeline control: whole pipe moves when the output slot frees ----
    assign advance  = !m_tvalid || m_tready;
    assign s_tready = advance;

    dtl_delay u_delay (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (advance),
        .s_valid      (s_tvalid),
        .sample       ($signed(s_tdata)),
        .delay_length (delay_length_reg),
        .tap          (tap)
    );

    dtl_filter u_filter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .tap     (tap),
        .alpha   (filter_coefficient_reg),
        .m_valid (m_tvalid),
        .m_data  (filt_data)
    );

    assign m_tdata = filt_data;

endmodule

// ----- dv/delay_then_one_pole_lowpass_test.sv -----
// Self-checking testbench for the delay line and one-pole low-pass block.
module delay_then_one_pole_lowpass_test
    import dtl_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  SETTLE_CYCLES = 8;        // margin beyond the pipeline latency
    localparam int  LONG_HOLD     = 250;      // receiver hold-off for the pressure test
    localparam int  RUN_LIMIT_NS  = 5_000_000;
    localparam longint FULL_SCALE = (longint'(1) << (SAMPLE_BITS - 1)) - 1;

    // receiver behaviour
    typedef enum int {
        SINK_ALWAYS,
        SINK_RANDOM,
        SINK_PATTERN
    } sink_mode_t;

    typedef logic [SAMPLE_BITS-1:0] sample_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [SAMPLE_BITS-1:0] s_tdata;   // [15:0] sample_in
    logic                  m_tvalid;
    logic                  m_tready;
    logic [SAMPLE_BITS-1:0] m_tdata;   // [15:0] sample_out
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    delay_then_one_pole_lowpass dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the delay line, filter and registers
    // ------------------------------------------------------------------
    sample_t           delay_line [DELAY_DEPTH];
    int unsigned       wr_ptr;
    int unsigned       fill;
    longint            level;          // Q1.31 filter state
    logic [LEN_W-1:0]  cur_delay;
    logic [COEF_W-1:0] cur_coef;

    sample_t expected_out_q [$];       // filtered samples still to arrive

    int         n_errors;
    int         n_sent;
    int         n_results;
    int         n_settings;
    int         n_stalls;              // cycles the input was offered but refused
    int         hold_left;             // long receiver hold-off, counted by the sink
    sink_mode_t sink_mode;

    // 10 ns clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Safety net: generous fixed ceiling on run time
    initial begin
        #(RUN_LIMIT_NS);
        $display("timeout: %0d results still outstanding", expected_out_q.size());
        $display("** delay_then_one_pole_lowpass: FAILED **");
        $finish;
    end

    // One step of the block: write into the delay line, tap it, filter, rescale.
    function automatic sample_t lowpass_predict(input sample_t smp);
        int unsigned        len;
        int unsigned        rd;
        logic signed [SAMPLE_BITS-1:0] tap;
        longint             coef;
        longint             x;
        longint             diff;
        longint             mag;
        longint             res;
        len = cur_delay;
        if (len > DELAY_DEPTH - 1)
            len = DELAY_DEPTH - 1;
        tap = '0;
        delay_line[wr_ptr] = smp;
        if (fill < DELAY_DEPTH)
            fill++;
        // only taps entries that have been written since reset
        if (fill > len) begin
            rd  = (wr_ptr + DELAY_DEPTH - len) % DELAY_DEPTH;
            tap = delay_line[rd];
        end
        wr_ptr = (wr_ptr + 1) % DELAY_DEPTH;

        coef  = cur_coef;                          // zero-extended
        x     = longint'(tap) * (longint'(1) << (32 - SAMPLE_BITS));
        diff  = x - level;
        level = level + ((coef * diff) >>> 16);    // arithmetic shift = floor
        if (level > longint'(32'sh7FFF_FFFF))
            level = longint'(32'sh7FFF_FFFF);
        if (level < -longint'(64'h8000_0000))
            level = -longint'(64'h8000_0000);

        // truncate toward zero: scale the magnitude, then restore the sign
        mag = (level < 0) ? -level : level;
        res = (mag * FULL_SCALE) >>> 31;
        if (level < 0)
            res = -res;
        return res[SAMPLE_BITS-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Receiver: own stall pattern, plus a long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        int phase;
        phase    = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            phase++;
            if (hold_left > 0) begin
                m_tready  = 1'b0;
                hold_left = hold_left - 1;
            end else begin
                case (sink_mode)
                    SINK_ALWAYS:  m_tready = 1'b1;
                    SINK_RANDOM:  m_tready = ($urandom_range(0, 9) < 6);
                    SINK_PATTERN: m_tready = (phase % 7) inside {[0:3]} ? 1'b1 : 1'b0;
                    default:      m_tready = 1'b1;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every output transaction against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && !s_tready)
                n_stalls++;
            if (m_tvalid && m_tready) begin
                n_results++;
                if (expected_out_q.size() == 0) begin
                    $error("sample_out: unexpected transaction, got %0d", $signed(m_tdata));
                    n_errors++;
                end else begin
                    sample_t want;
                    want = expected_out_q.pop_front();
                    if (m_tdata !== want) begin
                        $error("sample_out mismatch: expected %0d, actual %0d",
                               $signed(want), $signed(m_tdata));
                        n_errors++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offer one sample; returns once the transaction has been taken.
    // s_tvalid stays high so back-to-back calls stream one per cycle while s_tready is high.
    task automatic send_sample(input sample_t smp);
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = smp;
        do @(posedge aclk); while (!s_tready);
        expected_out_q = {expected_out_q, lowpass_predict(smp)};
        n_sent++;
    endtask

    // Play a list of samples, optionally in bursts with idle gaps between them.
    task automatic play_samples(input sample_t samples [$], input bit bursty);
        int burst_left;
        int gap;
        burst_left = $urandom_range(1, 24);
        foreach (samples[i]) begin
            if (bursty && burst_left == 0) begin
                gap = $urandom_range(0, 8);
                if (gap > 0) begin
                    @(negedge aclk);
                    s_tvalid = 1'b0;
                    repeat (gap - 1) @(negedge aclk);
                end
                burst_left = $urandom_range(1, 24);
            end
            send_sample(samples[i]);
            burst_left--;
        end
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    // Sender pause: hold off until every prediction has been matched, then settle.
    task automatic drain_stream();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (expected_out_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // APB write: setup then access phase; only ever called with the stream drained.
    task automatic write_register(input dtl_reg_t which, input logic [APB_DATA_W-1:0] value);
        drain_stream();
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {which, 2'b00};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        case (which)
            REG_DELAY_LENGTH: cur_delay = value[LEN_W-1:0];
            REG_FILTER_COEF:  cur_coef  = value[COEF_W-1:0];
            default: ;
        endcase
        n_settings++;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Mostly full-range noise, with rails and quiet passages mixed in.
    function automatic sample_t random_sample();
        int pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0:       return sample_t'(16'h7FFF);
            1:       return sample_t'(16'h8000);
            2, 3:    return sample_t'($urandom_range(0, 600) - 300);
            default: return sample_t'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values: long default delay, so the filter only ever sees zeros.
    task automatic test_reset_defaults();
        sample_t s [$];
        sink_mode = SINK_ALWAYS;
        s = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
        play_samples(s, 1'b0);
    endtask

    // Zero delay with the fastest coefficient: the filter chases the rails.
    task automatic test_passthrough_extremes();
        sample_t s [$];
        write_register(REG_DELAY_LENGTH, 32'd0);
        write_register(REG_FILTER_COEF, 32'd65535);
        s = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 16'h0001, 16'hFFFF};
        play_samples(s, 1'b0);
    endtask

    // Coefficient zero: the level must hold whatever comes in.
    task automatic test_coefficient_zero();
        sample_t s [$];
        write_register(REG_DELAY_LENGTH, 32'd1);
        write_register(REG_FILTER_COEF, 32'd0);
        s = '{16'h8000, 16'h7FFF, 16'h1234};
        play_samples(s, 1'b0);
    endtask

    // Longest delay: fill count is far below it, so the tap reads zero
    // and the filter decays.
    task automatic test_longest_delay();
        sample_t s [$];
        write_register(REG_DELAY_LENGTH, 32'd65535);
        write_register(REG_FILTER_COEF, 32'd40000);
        s = '{16'h7FFF, 16'h8000, 16'h4000};
        play_samples(s, 1'b0);
    endtask

    // Delay shortened between runs: the tap moves at once to the new length.
    task automatic test_delay_change();
        sample_t s [$];
        write_register(REG_DELAY_LENGTH, 32'd3);
        write_register(REG_FILTER_COEF, 32'd20000);
        s = '{16'h1000, 16'h2000, 16'hC000, 16'h7FFF};
        play_samples(s, 1'b0);
        write_register(REG_DELAY_LENGTH, 32'd1);
        s = '{16'h0100, 16'hFF00, 16'h8000};
        play_samples(s, 1'b0);
    endtask

    // Random streams over a spread of settings, idling on both sides.
    task automatic test_random_stream();
        sample_t s [$];
        int      n;
        for (int ph = 0; ph < 9; ph++) begin
            case (ph)
                0: begin
                    write_register(REG_DELAY_LENGTH, 32'd0);
                    write_register(REG_FILTER_COEF, 32'd65535);
                end
                4: begin
                    write_register(REG_DELAY_LENGTH, 32'($urandom_range(100, 500)));
                    write_register(REG_FILTER_COEF, 32'($urandom_range(0, 65535)));
                end
                6: begin
                    write_register(REG_DELAY_LENGTH, 32'($urandom_range(1, 40)));
                    write_register(REG_FILTER_COEF, 32'd0);
                end
                8: begin
                    write_register(REG_DELAY_LENGTH, 32'd65535);
                    write_register(REG_FILTER_COEF, 32'($urandom_range(30000, 65535)));
                end
                default: begin
                    write_register(REG_DELAY_LENGTH, 32'($urandom_range(0, 40)));
                    write_register(REG_FILTER_COEF, 32'($urandom));
                end
            endcase
            sink_mode = sink_mode_t'(ph % 3);
            n = $urandom_range(60, 75);
            s.delete();
            repeat (n) s = {s, random_sample()};
            // phase 2 streams without sender gaps
            play_samples(s, ph != 2);
        end
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering:
    // the pipeline fills and s_tready must drop.
    task automatic test_backpressure();
        sample_t s [$];
        write_register(REG_DELAY_LENGTH, 32'd7);
        write_register(REG_FILTER_COEF, 32'd12000);
        sink_mode = SINK_ALWAYS;
        hold_left = LONG_HOLD;
        repeat (40) s = {s, random_sample()};
        play_samples(s, 1'b0);
        drain_stream();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        sink_mode = SINK_ALWAYS;
        hold_left = 0;
        n_errors  = 0;
        n_sent    = 0;
        n_results = 0;
        n_settings = 0;
        n_stalls  = 0;

        // predictor starts from the reset state
        wr_ptr    = 0;
        fill      = 0;
        level     = 0;
        cur_delay = DELAY_LENGTH_RESET;
        cur_coef  = FILTER_COEF_RESET;

        aresetn = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_defaults();
        test_passthrough_extremes();
        test_coefficient_zero();
        test_longest_delay();
        test_delay_change();
        test_random_stream();
        test_backpressure();

        drain_stream();

        $display("Run covered %0d sample transactions over %0d register writes;",
                 n_sent, n_settings);
        $display("%0d filtered results checked, input held back on %0d cycles.",
                 n_results, n_stalls);
        if (n_errors == 0 && expected_out_q.size() == 0) begin
            $display("** delay_then_one_pole_lowpass: PASSED **");
        end else begin
            $display("** delay_then_one_pole_lowpass: FAILED **");
        end
        $finish;
    end

endmodule
